>>> hdl/owdbm_pkg.sv
// Types, codes and timing helpers for the dual-line 1-Wire bus master.
// Used by one_wire_dual_bus_master; depends on nothing else.
`default_nettype none

package owdbm_pkg;

   localparam int unsigned NumRegs = 8;
   localparam int unsigned RegIdxW = $clog2(NumRegs);
   localparam int unsigned CsrDataW = 10;
   localparam int unsigned CountW = 10;
   localparam int unsigned BitIdxW = 3;
   localparam int unsigned ByteW = 8;
   // Chained phase ends on one tick: reset low, presence wait, recovery.
   localparam int unsigned MaxChain = 3;

   localparam logic [CountW-1:0] ReadLowUs = 10'd2;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RST_LOW   = 3'd1,
      PH_RST_WAIT  = 3'd2,
      PH_RST_RECOV = 3'd3,
      PH_BIT_LOW   = 3'd4,
      PH_BIT_HIGH  = 3'd5,
      PH_BIT_GAP   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CMD_RESET = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [RegIdxW-1:0] {
      REG_RESET_LOW       = 3'd0,
      REG_PRESENCE_SAMPLE = 3'd1,
      REG_RESET_RECOVERY  = 3'd2,
      REG_WRITE_ONE_LOW   = 3'd3,
      REG_WRITE_ZERO_LOW  = 3'd4,
      REG_READ_SAMPLE     = 3'd5,
      REG_READ_RECOVERY   = 3'd6,
      REG_BIT_GAP         = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [7:0] presence_sample_us;
      logic [9:0] reset_recovery_us;
      logic [3:0] write_one_low_us;
      logic [6:0] write_zero_low_us;
      logic [5:0] read_sample_us;
      logic [6:0] read_recovery_us;
      logic [4:0] bit_gap_us;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      reset_low_us:       10'd485,
      presence_sample_us: 8'd65,
      reset_recovery_us:  10'd500,
      write_one_low_us:   4'd3,
      write_zero_low_us:  7'd65,
      read_sample_us:     6'd13,
      read_recovery_us:   7'd45,
      bit_gap_us:         5'd5
   };

   // Length in microseconds of the given phase.
   function automatic logic [CountW-1:0] phase_len(phase_type ph, logic rd, logic bitv,
                                                   cfg_type c);
      logic [CountW-1:0] len;
      len = '0;
      unique case (ph)
         PH_RST_LOW:   len = c.reset_low_us;
         PH_RST_WAIT:  len = CountW'(c.presence_sample_us);
         PH_RST_RECOV: len = c.reset_recovery_us;
         PH_BIT_LOW: begin
            if (rd) len = ReadLowUs;
            else if (bitv) len = CountW'(c.write_one_low_us);
            else len = CountW'(c.write_zero_low_us);
         end
         PH_BIT_HIGH: begin
            if (rd) len = CountW'(c.read_sample_us);
            else if (bitv) len = CountW'(c.write_zero_low_us);
            else len = CountW'(c.write_one_low_us);
         end
         PH_BIT_GAP: begin
            if (rd) len = CountW'(c.read_recovery_us);
            else len = CountW'(c.bit_gap_us);
         end
         default: len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> hdl/one_wire_dual_bus_master.sv
// Dual-line 1-Wire bus master: one result beat for every accepted request beat.
// The result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle; the result register drains while the next
// request is taken, so the rate is set only by the consumer's ready.
// Reset (synchronous, active high) restores the timing registers to their
// defaults, returns the sequencer to idle and clears the captured bytes and flags.
`default_nettype none

module one_wire_dual_bus_master
   import owdbm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   input  wire logic [1:0]           req_command,
   input  wire logic [ByteW-1:0]     req_write_data,
   input  wire logic                 req_line_level_a,
   input  wire logic                 req_line_level_b,
   // Response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_pull_low_a,
   output logic                      rsp_pull_low_b,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res,
   output logic                      rsp_absent_a,
   output logic                      rsp_absent_b,
   output logic [ByteW-1:0]          rsp_read_byte_a,
   output logic [ByteW-1:0]          rsp_read_byte_b,
   // Register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [RegIdxW-1:0]   csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wdata
);

   cfg_type                cfg_ff;
   phase_type              phase_ff, phase_in;
   cmd_type                cmd_ff, cmd_in;
   logic [CountW-1:0]      count_ff, count_in;
   logic [BitIdxW-1:0]     bit_ff, bit_in;
   logic [ByteW-1:0]       send_ff, send_in;
   logic [ByteW-1:0]       shift_a_ff, shift_a_in;
   logic [ByteW-1:0]       shift_b_ff, shift_b_in;
   logic                   miss_a_ff, miss_a_in;
   logic                   miss_b_ff, miss_b_in;
   logic                   done_in;

   logic                   rsp_valid_ff;
   logic                   pull_ff, busy_ff, done_ff;
   logic                   accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Register writes; data wider than a register is truncated to its width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_RESET_LOW:       cfg_ff.reset_low_us       <= csr_wdata;
            REG_PRESENCE_SAMPLE: cfg_ff.presence_sample_us <= csr_wdata[7:0];
            REG_RESET_RECOVERY:  cfg_ff.reset_recovery_us  <= csr_wdata;
            REG_WRITE_ONE_LOW:   cfg_ff.write_one_low_us   <= csr_wdata[3:0];
            REG_WRITE_ZERO_LOW:  cfg_ff.write_zero_low_us  <= csr_wdata[6:0];
            REG_READ_SAMPLE:     cfg_ff.read_sample_us     <= csr_wdata[5:0];
            REG_READ_RECOVERY:   cfg_ff.read_recovery_us   <= csr_wdata[6:0];
            REG_BIT_GAP:         cfg_ff.bit_gap_us         <= csr_wdata[4:0];
            default:             cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   // Next state for one beat. A tick may end several phases in a row when
   // the following phases have zero length, so the phase end is repeated a
   // bounded number of times with the count restarting at zero.
   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      bit_in     = bit_ff;
      send_in    = send_ff;
      shift_a_in = shift_a_ff;
      shift_b_in = shift_b_ff;
      miss_a_in  = miss_a_ff;
      miss_b_in  = miss_b_ff;
      done_in    = 1'b0;

      if (req_mode) begin
         if (phase_ff == PH_IDLE) begin
            unique case (req_command)
               CMD_RESET: begin
                  cmd_in   = CMD_RESET;
                  count_in = '0;
                  bit_in   = '0;
                  phase_in = PH_RST_LOW;
               end
               CMD_WRITE: begin
                  cmd_in   = CMD_WRITE;
                  count_in = '0;
                  bit_in   = '0;
                  phase_in = PH_BIT_LOW;
                  send_in  = req_write_data;
               end
               CMD_READ: begin
                  cmd_in     = CMD_READ;
                  count_in   = '0;
                  bit_in     = '0;
                  phase_in   = PH_BIT_LOW;
                  shift_a_in = '0;
                  shift_b_in = '0;
               end
               default: cmd_in = cmd_ff;
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         count_in = count_ff + CountW'(1);
         for (int k = 0; k < MaxChain; k++) begin
            if (phase_in != PH_IDLE &&
                count_in >= phase_len(phase_in, cmd_in == CMD_READ,
                                      send_in[bit_in], cfg_ff)) begin
               count_in = '0;
               unique case (phase_in)
                  PH_RST_LOW:  phase_in = PH_RST_WAIT;
                  PH_RST_WAIT: begin
                     miss_a_in = req_line_level_a;
                     miss_b_in = req_line_level_b;
                     phase_in  = PH_RST_RECOV;
                  end
                  PH_RST_RECOV: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
                  PH_BIT_LOW:  phase_in = PH_BIT_HIGH;
                  PH_BIT_HIGH: begin
                     if (cmd_in == CMD_READ) begin
                        shift_a_in[bit_in] = shift_a_in[bit_in] | req_line_level_a;
                        shift_b_in[bit_in] = shift_b_in[bit_in] | req_line_level_b;
                     end
                     phase_in = PH_BIT_GAP;
                  end
                  PH_BIT_GAP: begin
                     if (bit_in == BitIdxW'(ByteW - 1)) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        bit_in   = bit_in + BitIdxW'(1);
                        phase_in = PH_BIT_LOW;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cmd_ff     <= CMD_RESET;
         count_ff   <= '0;
         bit_ff     <= '0;
         send_ff    <= '0;
         shift_a_ff <= '0;
         shift_b_ff <= '0;
         miss_a_ff  <= 1'b0;
         miss_b_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         count_ff   <= count_in;
         bit_ff     <= bit_in;
         send_ff    <= send_in;
         shift_a_ff <= shift_a_in;
         shift_b_ff <= shift_b_in;
         miss_a_ff  <= miss_a_in;
         miss_b_ff  <= miss_b_in;
      end
   end

   // Result register: the flags of the beat just accepted. The sticky
   // values (flags and bytes) come straight from the state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pull_ff <= (phase_in == PH_RST_LOW) || (phase_in == PH_BIT_LOW);
         busy_ff <= (phase_in != PH_IDLE);
         done_ff <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pull_low_a  = pull_ff;
   assign rsp_pull_low_b  = pull_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_absent_a    = miss_a_ff;
   assign rsp_absent_b    = miss_b_ff;
   assign rsp_read_byte_a = shift_a_ff;
   assign rsp_read_byte_b = shift_b_ff;

endmodule

`default_nettype wire

>>> sim/tb_one_wire_dual_bus_master.sv
// Self-checking testbench for the dual-line 1-Wire bus master: ticks and commands go in as
// request beats and each result beat is compared with a cycle-free model of the sequencer.
// Depends on owdbm_pkg and one_wire_dual_bus_master; needs nothing else.
`timescale 1ns / 100ps

module tb_one_wire_dual_bus_master
   import owdbm_pkg::*;
();

   localparam logic ModeTick = 1'b0;
   localparam logic ModeCommand = 1'b1;
   localparam logic [1:0] CmdUnused = 2'd3;

   localparam cfg_type TimingFloor = '{
      reset_low_us:       10'd0,
      presence_sample_us: 8'd0,
      reset_recovery_us:  10'd0,
      write_one_low_us:   4'd1,
      write_zero_low_us:  7'd1,
      read_sample_us:     6'd1,
      read_recovery_us:   7'd0,
      bit_gap_us:         5'd0
   };

   typedef struct packed {
      logic             mode;
      logic [1:0]       command;
      logic [ByteW-1:0] data;
      logic             level_a;
      logic             level_b;
   } bus_item_type;

   typedef struct packed {
      logic             pull_a;
      logic             pull_b;
      logic             busy;
      logic             done;
      logic             absent_a;
      logic             absent_b;
      logic [ByteW-1:0] byte_a;
      logic [ByteW-1:0] byte_b;
   } line_result_type;

   typedef struct packed {
      phase_type           ph;
      cmd_type             cmd;
      logic [CountW-1:0]   count;
      logic [BitIdxW-1:0]  bit_idx;
      logic [ByteW-1:0]    send;
      logic [ByteW-1:0]    shift_a;
      logic [ByteW-1:0]    shift_b;
      logic                miss_a;
      logic                miss_b;
   } master_state_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = 1'b0;
   logic [1:0]          req_command = '0;
   logic [ByteW-1:0]    req_write_data = '0;
   logic                req_line_level_a = 1'b0;
   logic                req_line_level_b = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_pull_low_a;
   logic                rsp_pull_low_b;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic                rsp_absent_a;
   logic                rsp_absent_b;
   logic [ByteW-1:0]    rsp_read_byte_a;
   logic [ByteW-1:0]    rsp_read_byte_b;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [RegIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   bus_item_type     tick_cmd_fifo[$];
   line_result_type  line_state_fifo[$];
   bus_item_type     driven_item;
   master_state_type seq_model;
   cfg_type          timing;
   int               items_queued = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   int unsigned      stall_tick = 0;
   int               stall_mode = 0;
   int               errors = 0;

   one_wire_dual_bus_master u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_command      (req_command),
      .req_write_data   (req_write_data),
      .req_line_level_a (req_line_level_a),
      .req_line_level_b (req_line_level_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pull_low_a   (rsp_pull_low_a),
      .rsp_pull_low_b   (rsp_pull_low_b),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_absent_a     (rsp_absent_a),
      .rsp_absent_b     (rsp_absent_b),
      .rsp_read_byte_a  (rsp_read_byte_a),
      .rsp_read_byte_b  (rsp_read_byte_b),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Duration of the sequencer's current phase under the programmed timing.
   function automatic logic [CountW-1:0] slot_length(phase_type ph);
      logic              rd;
      logic              bitv;
      logic [CountW-1:0] len;
      rd = (seq_model.cmd == CMD_READ);
      bitv = seq_model.send[seq_model.bit_idx];
      case (ph)
         PH_RST_LOW:   len = timing.reset_low_us;
         PH_RST_WAIT:  len = CountW'(timing.presence_sample_us);
         PH_RST_RECOV: len = timing.reset_recovery_us;
         PH_BIT_LOW: begin
            if (rd) len = ReadLowUs;
            else len = bitv ? CountW'(timing.write_one_low_us)
                            : CountW'(timing.write_zero_low_us);
         end
         PH_BIT_HIGH: begin
            if (rd) len = CountW'(timing.read_sample_us);
            else len = bitv ? CountW'(timing.write_zero_low_us)
                            : CountW'(timing.write_one_low_us);
         end
         PH_BIT_GAP: begin
            len = rd ? CountW'(timing.read_recovery_us) : CountW'(timing.bit_gap_us);
         end
         default: len = '0;
      endcase
      return len;
   endfunction

   // Applies one tick or command to the sequencer model and returns the line state after it.
   function automatic line_result_type step_sequencer(bus_item_type it);
      line_result_type r;
      logic            done;
      done = 1'b0;
      if (it.mode == ModeCommand) begin
         if (seq_model.ph == PH_IDLE && it.command inside {CMD_RESET, CMD_WRITE, CMD_READ}) begin
            seq_model.cmd = cmd_type'(it.command);
            seq_model.count = '0;
            seq_model.bit_idx = '0;
            if (it.command == CMD_RESET) begin
               seq_model.ph = PH_RST_LOW;
            end else begin
               seq_model.ph = PH_BIT_LOW;
               if (it.command == CMD_WRITE) begin
                  seq_model.send = it.data;
               end else begin
                  seq_model.shift_a = '0;
                  seq_model.shift_b = '0;
               end
            end
         end
      end else if (seq_model.ph != PH_IDLE) begin
         seq_model.count = seq_model.count + CountW'(1);
         // Zero-length phases fall through within the same tick.
         while (seq_model.ph != PH_IDLE && seq_model.count >= slot_length(seq_model.ph)) begin
            seq_model.count = '0;
            case (seq_model.ph)
               PH_RST_LOW: seq_model.ph = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  seq_model.miss_a = it.level_a;
                  seq_model.miss_b = it.level_b;
                  seq_model.ph = PH_RST_RECOV;
               end
               PH_RST_RECOV: begin
                  seq_model.ph = PH_IDLE;
                  done = 1'b1;
               end
               PH_BIT_LOW: seq_model.ph = PH_BIT_HIGH;
               PH_BIT_HIGH: begin
                  if (seq_model.cmd == CMD_READ) begin
                     seq_model.shift_a[seq_model.bit_idx] =
                        seq_model.shift_a[seq_model.bit_idx] | it.level_a;
                     seq_model.shift_b[seq_model.bit_idx] =
                        seq_model.shift_b[seq_model.bit_idx] | it.level_b;
                  end
                  seq_model.ph = PH_BIT_GAP;
               end
               PH_BIT_GAP: begin
                  if (&seq_model.bit_idx) begin
                     seq_model.ph = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     seq_model.bit_idx = seq_model.bit_idx + BitIdxW'(1);
                     seq_model.ph = PH_BIT_LOW;
                  end
               end
               default: seq_model.ph = PH_IDLE;
            endcase
         end
      end
      r.pull_a = (seq_model.ph == PH_RST_LOW || seq_model.ph == PH_BIT_LOW);
      r.pull_b = r.pull_a;
      r.busy = (seq_model.ph != PH_IDLE);
      r.done = done;
      r.absent_a = seq_model.miss_a;
      r.absent_b = seq_model.miss_b;
      r.byte_a = seq_model.shift_a;
      r.byte_b = seq_model.shift_b;
      return r;
   endfunction

   // Number of ticks an operation takes from its command to its last phase end.
   function automatic int op_ticks(cmd_type c);
      int n;
      case (c)
         CMD_RESET: n = int'(timing.reset_low_us) + int'(timing.presence_sample_us)
                        + int'(timing.reset_recovery_us) + int'(timing.reset_low_us == '0);
         CMD_WRITE: n = 8 * (int'(timing.write_one_low_us) + int'(timing.write_zero_low_us)
                             + int'(timing.bit_gap_us));
         default:   n = 8 * (int'(ReadLowUs) + int'(timing.read_sample_us)
                             + int'(timing.read_recovery_us));
      endcase
      return n;
   endfunction

   function automatic logic [ByteW-1:0] pick_byte();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return ByteW'($urandom);
   endfunction

   function automatic cfg_type random_timing();
      cfg_type c;
      c.reset_low_us = 10'($urandom_range(0, 16));
      c.presence_sample_us = 8'($urandom_range(0, 8));
      c.reset_recovery_us = 10'($urandom_range(0, 16));
      c.write_one_low_us = 4'($urandom_range(1, 3));
      c.write_zero_low_us = 7'($urandom_range(1, 6));
      c.read_sample_us = 6'($urandom_range(1, 4));
      c.read_recovery_us = 7'($urandom_range(0, 4));
      c.bit_gap_us = 5'($urandom_range(0, 3));
      return c;
   endfunction

   task automatic queue_item(logic mode, logic [1:0] code, logic [ByteW-1:0] data,
                             logic la, logic lb);
      tick_cmd_fifo.push_back('{mode: mode, command: code, data: data,
                                level_a: la, level_b: lb});
      items_queued++;
   endtask

   task automatic queue_tick();
      queue_item(ModeTick, 2'($urandom), ByteW'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // A command followed by enough ticks to finish it, with the odd stray command mixed in.
   task automatic queue_operation(cmd_type c);
      int span;
      span = op_ticks(c) + $urandom_range(0, 3);
      queue_item(ModeCommand, c, pick_byte(), 1'($urandom), 1'($urandom));
      repeat (span) begin
         if ($urandom_range(0, 29) == 0)
            queue_item(ModeCommand, 2'($urandom), pick_byte(), 1'($urandom), 1'($urandom));
         queue_tick();
      end
   endtask

   task automatic queue_traffic(int budget);
      int start;
      start = items_queued;
      while (items_queued - start < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_operation(cmd_type'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 6))
               queue_item(1'($urandom), 2'($urandom), pick_byte(), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic write_reg(reg_idx_type idx, logic [CsrDataW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      // Bits above a register's width are dropped.
      case (idx)
         REG_RESET_LOW:       timing.reset_low_us = val[9:0];
         REG_PRESENCE_SAMPLE: timing.presence_sample_us = val[7:0];
         REG_RESET_RECOVERY:  timing.reset_recovery_us = val[9:0];
         REG_WRITE_ONE_LOW:   timing.write_one_low_us = val[3:0];
         REG_WRITE_ZERO_LOW:  timing.write_zero_low_us = val[6:0];
         REG_READ_SAMPLE:     timing.read_sample_us = val[5:0];
         REG_READ_RECOVERY:   timing.read_recovery_us = val[6:0];
         default:             timing.bit_gap_us = val[4:0];
      endcase
   endtask

   task automatic load_timing(cfg_type c);
      write_reg(REG_RESET_LOW, c.reset_low_us);
      write_reg(REG_PRESENCE_SAMPLE, {2'($urandom), c.presence_sample_us});
      write_reg(REG_RESET_RECOVERY, c.reset_recovery_us);
      write_reg(REG_WRITE_ONE_LOW, {6'($urandom), c.write_one_low_us});
      write_reg(REG_WRITE_ZERO_LOW, {3'($urandom), c.write_zero_low_us});
      write_reg(REG_READ_SAMPLE, {4'($urandom), c.read_sample_us});
      write_reg(REG_READ_RECOVERY, {3'($urandom), c.read_recovery_us});
      write_reg(REG_BIT_GAP, {5'($urandom), c.bit_gap_us});
   endtask

   // Waits until every beat has been sent and checked and the sequencer is back to idle.
   task automatic settle();
      forever begin
         @(negedge clock);
         while (tick_cmd_fifo.size() != 0 || req_valid || line_state_fifo.size() != 0)
            @(negedge clock);
         if (seq_model.ph == PH_IDLE) begin
            repeat (3) @(posedge clock);
            return;
         end
         repeat (32) queue_tick();
      end
   endtask

   task automatic compare_field(string name, logic [ByteW-1:0] want_v, logic [ByteW-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   // Request driver: beats go out in bursts with random gaps, and each accepted beat is
   // run through the model.
   always @(posedge clock) begin
      if (reset) begin
         seq_model = '0;
         timing = CfgReset;
         burst_left = 0;
         gap_left = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            line_state_fifo.push_back(step_sequencer(driven_item));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_cmd_fifo.size() > 0) begin
               driven_item = tick_cmd_fifo.pop_front();
               req_valid <= 1'b1;
               req_mode <= driven_item.mode;
               req_command <= driven_item.command;
               req_write_data <= driven_item.data;
               req_line_level_a <= driven_item.level_a;
               req_line_level_b <= driven_item.level_b;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                           : $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with its own stall pattern, redrawn at random from three patterns as it runs.
   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (line_state_fifo.size() == 0) begin
               $display("%0t: result beat arrived with no prediction pending", $time);
               errors++;
            end else begin
               want = line_state_fifo.pop_front();
               compare_field("pull_low_a", want.pull_a, rsp_pull_low_a);
               compare_field("pull_low_b", want.pull_b, rsp_pull_low_b);
               compare_field("busy_res", want.busy, rsp_busy_res);
               compare_field("done_res", want.done, rsp_done_res);
               compare_field("absent_a", want.absent_a, rsp_absent_a);
               compare_field("absent_b", want.absent_b, rsp_absent_b);
               compare_field("read_byte_a", want.byte_a, rsp_read_byte_a);
               compare_field("read_byte_b", want.byte_b, rsp_read_byte_b);
            end
         end
         stall_tick++;
         if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= (stall_tick % 7) > 2;
         endcase
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Shortest timing: a reset of all zero-length phases finishes on the tick after its
      // command, and a command arriving mid-write must be dropped.
      load_timing(TimingFloor);
      queue_item(ModeTick, CMD_RESET, 8'h00, 1'b1, 1'b1);
      queue_item(ModeCommand, CmdUnused, 8'hFF, 1'b1, 1'b1);
      queue_item(ModeCommand, CMD_RESET, 8'h00, 1'b0, 1'b0);
      queue_item(ModeTick, CMD_RESET, 8'h00, 1'b1, 1'b0);
      queue_item(ModeCommand, CMD_RESET, 8'h00, 1'b1, 1'b1);
      queue_item(ModeTick, CMD_READ, 8'hFF, 1'b0, 1'b1);
      queue_item(ModeCommand, CMD_WRITE, 8'hFF, 1'b0, 1'b0);
      queue_item(ModeCommand, CMD_READ, 8'h00, 1'b1, 1'b1);
      repeat (16) queue_tick();
      settle();

      for (int p = 0; p < 7; p++) begin
         load_timing((p == 0) ? TimingFloor : random_timing());
         queue_traffic(85);
         settle();
      end

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> one_wire_dual_bus_master.f
hdl/owdbm_pkg.sv
hdl/one_wire_dual_bus_master.sv
sim/tb_one_wire_dual_bus_master.sv
